[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCIT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCIT_ASSERT(label, prop, msg)
`define PCIT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hw/rtl/pcit_pkg.sv]
// ----------------------------------------------------------------------------
// pcit_pkg
// Types, codes and helpers shared by the character intern table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcit_pkg;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;
    localparam int LEN_W      = 4;

    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_ERROR     = 2'd1;
    localparam logic [1:0] STATUS_BAD_WIDTH = 2'd2;

    localparam logic [31:0] CODE_SPACE_ONE = 32'h0000_2001;
    localparam logic [31:0] CODE_SPACE_TWO = 32'h0020_2022;
    localparam logic [31:0] CODE_ONE_BYTE  = 32'h0000_0001;
    localparam logic [63:0] SPACE_BYTES    = 64'h2020_2020_2020_2020;

    localparam logic [7:0] WIDTH_ONE = 8'd1;
    localparam logic [7:0] WIDTH_TWO = 8'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    function automatic logic [63:0] byte_mask(input logic [4:0] count);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (5'(i) < count) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pcit_store.sv]
// ----------------------------------------------------------------------------
// pcit_store
// Intern table storage: entry bytes and lengths, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcit_store
    import pcit_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  wire logic              clk,
    input  wire mem_ctl_t          ctl,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [63:0]       wbytes,
    input  wire logic [LEN_W-1:0]  wlen,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [63:0]            rbytes,
    output logic [LEN_W-1:0]       rlen
);

    logic [63:0]      bytes_mem [DEPTH];
    logic [LEN_W-1:0] len_mem [DEPTH];
    logic [63:0]      rbytes_reg;
    logic [LEN_W-1:0] rlen_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            bytes_mem[waddr] <= wbytes;
            len_mem[waddr]   <= wlen;
        end
        if (ctl.rd_en)
        begin
            rbytes_reg <= bytes_mem[raddr];
            rlen_reg   <= len_mem[raddr];
        end
    end

    assign rbytes = rbytes_reg;
    assign rlen   = rlen_reg;

endmodule

`default_nettype wire

[hw/rtl/packed_char_intern_table.sv]
// ----------------------------------------------------------------------------
// packed_char_intern_table
// Packs multi-byte characters into 32-bit codes and unpacks them, interning
// characters of four or more bytes in a table.
// ----------------------------------------------------------------------------
// Each word on the input stream yields exactly one word on the output stream.
// A pack of four or more bytes walks the stored entries one per cycle through
// the table's single read port until it finds a match or has compared every
// used entry; an unpack that reads the table waits in ST_UWAIT for the
// registered read, and every other word goes from ST_CHECK to ST_FINISH. The
// block accepts one word at a time, and a finished result waits in the output
// register while the next word is processed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module packed_char_intern_table
    import pcit_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int MAX_CHAR_BYTES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // char_width[7:0], byte_count[12:8], char_bytes[76:13], packed_code[108:77]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[1:0], code_out[33:2], size_out[38:34], width_out[40:39],
    // bytes_out[104:41]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_UWAIT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic           op_reg, op_next;
    logic [7:0]     w_reg, w_next;
    logic [4:0]     n_reg, n_next;
    logic [63:0]    data_reg, data_next;
    logic [31:0]    code_reg, code_next;
    logic [UW-1:0]  k_reg, k_next;
    logic           pend_reg, pend_next;
    logic [IW-1:0]  pidx_reg, pidx_next;
    logic [UW-1:0]  used_reg, used_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [31:0]    res_code_reg, res_code_next;
    logic [4:0]     res_size_reg, res_size_next;
    logic [1:0]     res_width_reg, res_width_next;
    logic [63:0]    res_bytes_reg, res_bytes_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic           m_valid_reg, m_valid_next;

    mem_ctl_t         mem_ctl;
    logic [IW-1:0]    mem_raddr;
    logic [63:0]      mem_rbytes;
    logic [LEN_W-1:0] mem_rlen;

    logic        wide;
    logic [7:0]  flags;
    logic [31:0] space_code;
    logic [4:0]  cap;
    logic        match;
    logic [63:0] n_mask;

    assign wide       = (w_reg == WIDTH_TWO);
    assign flags      = {2'b00, wide, n_reg};
    assign space_code = wide ? CODE_SPACE_TWO : CODE_SPACE_ONE;
    assign cap        = (code_reg[4:0] > 5'(MAX_CHAR_BYTES)) ? 5'(MAX_CHAR_BYTES)
                                                              : code_reg[4:0];
    assign match      = pend_reg && (mem_rlen == n_reg[LEN_W-1:0])
                        && (mem_rbytes == data_reg);
    assign n_mask     = byte_mask(n_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        data_next       = data_reg;
        code_next       = code_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_code_next   = res_code_reg;
        res_size_next   = res_size_reg;
        res_width_next  = res_width_reg;
        res_bytes_next  = res_bytes_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        mem_ctl         = '0;
        mem_raddr       = k_reg[IW-1:0];

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    w_next     = s_axis_tdata[7:0];
                    n_next     = s_axis_tdata[12:8];
                    data_next  = s_axis_tdata[76:13];
                    code_next  = s_axis_tdata[108:77];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
                if (op_reg == OP_PACK)
                begin
                    res_status_next = STATUS_DONE;
                    res_size_next   = 5'd0;
                    res_width_next  = 2'd1;
                    res_bytes_next  = 64'd0;
                    if (w_reg != WIDTH_ONE && w_reg != WIDTH_TWO)
                    begin
                        res_status_next = STATUS_BAD_WIDTH;
                        res_code_next   = CODE_SPACE_ONE;
                    end
                    else if (n_reg > 5'(MAX_CHAR_BYTES))
                    begin
                        res_status_next = STATUS_ERROR;
                        res_code_next   = space_code;
                    end
                    else if (n_reg == 5'd1)
                    begin
                        res_code_next = CODE_ONE_BYTE | {16'd0, data_reg[7:0], 8'd0};
                    end
                    else if (n_reg < 5'd4)
                    begin
                        res_code_next = {data_reg[23:0] & n_mask[23:0], flags};
                    end
                    else
                    begin
                        data_next  = data_reg & byte_mask(n_reg);
                        k_next     = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    res_status_next = STATUS_DONE;
                    res_code_next   = 32'd0;
                    res_size_next   = code_reg[4:0];
                    res_width_next  = code_reg[5] ? 2'd2 : 2'd1;
                    if (code_reg[4:0] < 5'd4)
                    begin
                        res_bytes_next = {40'd0, code_reg[31:8]} & byte_mask(code_reg[4:0]);
                    end
                    else if (25'(code_reg[31:8]) >= 25'(used_reg))
                    begin
                        res_bytes_next = SPACE_BYTES & byte_mask(cap);
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr     = code_reg[IW+7:8];
                        state_next    = ST_UWAIT;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (k_reg < used_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    k_next        = k_reg + UW'(1);
                    pend_next     = 1'b1;
                    pidx_next     = k_reg[IW-1:0];
                end
                if (match)
                begin
                    mem_ctl.rd_en = 1'b0;
                    res_code_next = {24'(pidx_reg), flags};
                    state_next    = ST_FINISH;
                end
                else if (!pend_reg && k_reg == used_reg)
                begin
                    if (used_reg == UW'(TABLE_ENTRIES))
                    begin
                        res_status_next = STATUS_ERROR;
                        res_code_next   = space_code;
                    end
                    else
                    begin
                        mem_ctl.wr_en = 1'b1;
                        used_next     = used_reg + UW'(1);
                        res_code_next = {24'(used_reg), flags};
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_UWAIT:
            begin
                res_bytes_next = mem_rbytes & byte_mask(cap);
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = {7'd0, res_bytes_reg, res_width_reg, res_size_reg,
                                    res_code_reg, res_status_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        w_reg          <= w_next;
        n_reg          <= n_next;
        data_reg       <= data_next;
        code_reg       <= code_next;
        k_reg          <= k_next;
        pidx_reg       <= pidx_next;
        res_status_reg <= res_status_next;
        res_code_reg   <= res_code_next;
        res_size_reg   <= res_size_next;
        res_width_reg  <= res_width_next;
        res_bytes_reg  <= res_bytes_next;
        m_data_reg     <= m_data_next;
    end

    pcit_store #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IW)
    ) u_store (
        .clk    (clk),
        .ctl    (mem_ctl),
        .waddr  (used_reg[IW-1:0]),
        .wbytes (data_reg),
        .wlen   (n_reg[LEN_W-1:0]),
        .raddr  (mem_raddr),
        .rbytes (mem_rbytes),
        .rlen   (mem_rlen)
    );

    `PCIT_ASSERT(a_used_bound, used_reg <= UW'(TABLE_ENTRIES), "Entry count exceeds table size.")
    `PCIT_ASSERT(a_write_in_scan, mem_ctl.wr_en |-> (state_reg == ST_SCAN), "Table written outside a scan.")
    `PCIT_ASSERT(a_write_counts, mem_ctl.wr_en |=> (used_reg == $past(used_reg) + UW'(1)), "Append did not advance the entry count.")
    `PCIT_ASSERT(a_pend_in_range, pend_reg |-> (UW'(pidx_reg) < used_reg), "Compared entry lies beyond the used entries.")

endmodule

`default_nettype wire
